>>> hdl/semigraphics_cell_color_match_top_defines.svh
// assertion macros used by the checker file
`ifndef SEMIGRAPHICS_CELL_COLOR_MATCH_TOP_DEFINES_SVH
`define SEMIGRAPHICS_CELL_COLOR_MATCH_TOP_DEFINES_SVH

// same-cycle implication, checked at every rising edge out of reset
`define SGCCM_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("sgccm checker violation");

// next-cycle implication
`define SGCCM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("sgccm checker violation");

`endif

>>> hdl/sgccm_pkg.sv
// shared types, constants and helpers of the cell color matcher
package sgccm_pkg;

    localparam int COEF_FRAC_BITS = 14;
    localparam int DOT_W   = COEF_FRAC_BITS + 10;
    localparam int SQ_W    = 2 * COEF_FRAC_BITS + 18;
    localparam int HALF_W  = SQ_W + 2;
    localparam int SCORE_W = HALF_W + 1;

    localparam int NUM_COLORS = 8;
    localparam int DIST_N     = NUM_COLORS + 1;
    localparam int DIST_BLACK = NUM_COLORS;
    localparam int NUM_CAND   = 25;
    localparam int IDX_W      = 5;
    localparam int PAL_W      = 24;
    localparam int CFG_ADDR_W = 3;
    localparam int IN_W       = 96;
    localparam int OUT_W      = 16;
    localparam int LAT        = 10;

    localparam logic [IDX_W-1:0] BLACK_INDEX = 5'd24;
    localparam logic [7:0] BYTE_BLACK = 8'h80;
    localparam logic [3:0] PAT_RIGHT  = 4'h5;
    localparam logic [3:0] PAT_LEFT   = 4'ha;
    localparam logic [3:0] PAT_BOTH   = 4'hf;

    // yiq coefficients rounded to nearest in fixed point
    localparam logic signed [DOT_W-1:0] K_YR =
        DOT_W'(((64'd299000 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);
    localparam logic signed [DOT_W-1:0] K_YG =
        DOT_W'(((64'd587000 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);
    localparam logic signed [DOT_W-1:0] K_YB =
        DOT_W'(((64'd114000 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);
    localparam logic signed [DOT_W-1:0] K_IR =
        DOT_W'(((64'd595716 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);
    localparam logic signed [DOT_W-1:0] K_IG =
        DOT_W'(((64'd274453 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);
    localparam logic signed [DOT_W-1:0] K_IB =
        DOT_W'(((64'd321263 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);
    localparam logic signed [DOT_W-1:0] K_QR =
        DOT_W'(((64'd211456 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);
    localparam logic signed [DOT_W-1:0] K_QG =
        DOT_W'(((64'd522591 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);
    localparam logic signed [DOT_W-1:0] K_QB =
        DOT_W'(((64'd311135 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [IDX_W-1:0]   idx;
    } cand_t;

    // candidate index to semigraphics byte
    function automatic logic [7:0] cell_byte_of(input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        b = {1'b1, idx[2], idx[1:0], 4'h0};
        if (idx == BLACK_INDEX)
        begin
            b = BYTE_BLACK;
        end
        else
        begin
            case (idx[4:3])
                2'd0:    b[3:0] = PAT_RIGHT;
                2'd1:    b[3:0] = PAT_LEFT;
                default: b[3:0] = PAT_BOTH;
            endcase
        end
        return b;
    endfunction

endpackage

>>> hdl/sgccm_half_dist.sv
// yiq squared distance of one half against every palette color and black
module sgccm_half_dist (
    input  logic                           clk,
    input  logic                           en,
    input  sgccm_pkg::rgb_t                avg,
    input  logic [sgccm_pkg::PAL_W-1:0]    pal [sgccm_pkg::NUM_COLORS],
    output logic [sgccm_pkg::HALF_W-1:0]   dists [sgccm_pkg::DIST_N]
);

    localparam int DW = sgccm_pkg::DOT_W;
    localparam int N  = sgccm_pkg::DIST_N;

    logic signed [DW-1:0] y_reg [N];
    logic signed [DW-1:0] i_reg [N];
    logic signed [DW-1:0] q_reg [N];
    logic signed [DW-1:0] y_next [N];
    logic signed [DW-1:0] i_next [N];
    logic signed [DW-1:0] q_next [N];
    logic [sgccm_pkg::SQ_W-1:0] ys_reg [N];
    logic [sgccm_pkg::SQ_W-1:0] is_reg [N];
    logic [sgccm_pkg::SQ_W-1:0] qs_reg [N];
    logic [sgccm_pkg::SQ_W-1:0] ys_next [N];
    logic [sgccm_pkg::SQ_W-1:0] is_next [N];
    logic [sgccm_pkg::SQ_W-1:0] qs_next [N];
    logic [sgccm_pkg::HALF_W-1:0] dist_reg [N];
    logic [sgccm_pkg::HALF_W-1:0] dist_next [N];

    function automatic logic [sgccm_pkg::SQ_W-1:0] square(input logic signed [DW-1:0] v);
        logic signed [2*DW-1:0] p;
        p = v * v;
        return p[sgccm_pkg::SQ_W-1:0];
    endfunction

    // stage a: channel differences and dot products
    always_comb
    begin
        logic [sgccm_pkg::PAL_W-1:0] col;
        logic signed [DW-1:0] dr;
        logic signed [DW-1:0] dg;
        logic signed [DW-1:0] db;
        for (int j = 0; j < N; j++)
        begin
            col = (j < sgccm_pkg::NUM_COLORS) ? pal[j[2:0]] : '0;
            dr = $signed(DW'(avg.red))   - $signed(DW'(col[23:16]));
            dg = $signed(DW'(avg.green)) - $signed(DW'(col[15:8]));
            db = $signed(DW'(avg.blue))  - $signed(DW'(col[7:0]));
            y_next[j] = sgccm_pkg::K_YR * dr + sgccm_pkg::K_YG * dg + sgccm_pkg::K_YB * db;
            i_next[j] = sgccm_pkg::K_IR * dr - sgccm_pkg::K_IG * dg - sgccm_pkg::K_IB * db;
            q_next[j] = sgccm_pkg::K_QR * dr - sgccm_pkg::K_QG * dg + sgccm_pkg::K_QB * db;
        end
    end

    // stage b: squares, stage c: sum
    always_comb
    begin
        for (int j = 0; j < N; j++)
        begin
            ys_next[j] = square(y_reg[j]);
            is_next[j] = square(i_reg[j]);
            qs_next[j] = square(q_reg[j]);
            dist_next[j] = sgccm_pkg::HALF_W'(ys_reg[j]) + sgccm_pkg::HALF_W'(is_reg[j])
                         + sgccm_pkg::HALF_W'(qs_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg    <= y_next;
            i_reg    <= i_next;
            q_reg    <= q_next;
            ys_reg   <= ys_next;
            is_reg   <= is_next;
            qs_reg   <= qs_next;
            dist_reg <= dist_next;
        end
    end

    assign dists = dist_reg;

endmodule

>>> hdl/sgccm_min_tree.sv
// registered minimum tree over the candidate scores, lowest index wins ties
module sgccm_min_tree (
    input  logic                            clk,
    input  logic                            en,
    input  logic [sgccm_pkg::SCORE_W-1:0]   score [sgccm_pkg::NUM_CAND],
    output logic [sgccm_pkg::IDX_W-1:0]     best_idx
);

    sgccm_pkg::cand_t lv0 [25];
    sgccm_pkg::cand_t lv1_reg [13];
    sgccm_pkg::cand_t lv1_next [13];
    sgccm_pkg::cand_t lv2_reg [7];
    sgccm_pkg::cand_t lv2_next [7];
    sgccm_pkg::cand_t lv3_reg [4];
    sgccm_pkg::cand_t lv3_next [4];
    sgccm_pkg::cand_t lv4_reg [2];
    sgccm_pkg::cand_t lv4_next [2];
    sgccm_pkg::cand_t best_reg;
    sgccm_pkg::cand_t best_next;

    // a always carries the lower index
    function automatic sgccm_pkg::cand_t pick(input sgccm_pkg::cand_t a,
                                              input sgccm_pkg::cand_t b);
        return (b.score < a.score) ? b : a;
    endfunction

    always_comb
    begin
        for (int i = 0; i < 25; i++)
        begin
            lv0[i].score = score[i];
            lv0[i].idx   = sgccm_pkg::IDX_W'(i);
        end
        for (int i = 0; i < 12; i++)
        begin
            lv1_next[i] = pick(lv0[2*i], lv0[2*i+1]);
        end
        lv1_next[12] = lv0[24];
        for (int i = 0; i < 6; i++)
        begin
            lv2_next[i] = pick(lv1_reg[2*i], lv1_reg[2*i+1]);
        end
        lv2_next[6] = lv1_reg[12];
        for (int i = 0; i < 3; i++)
        begin
            lv3_next[i] = pick(lv2_reg[2*i], lv2_reg[2*i+1]);
        end
        lv3_next[3] = lv2_reg[6];
        for (int i = 0; i < 2; i++)
        begin
            lv4_next[i] = pick(lv3_reg[2*i], lv3_reg[2*i+1]);
        end
        best_next = pick(lv4_reg[0], lv4_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lv1_reg  <= lv1_next;
            lv2_reg  <= lv2_next;
            lv3_reg  <= lv3_next;
            lv4_reg  <= lv4_next;
            best_reg <= best_next;
        end
    end

    assign best_idx = best_reg.idx;

endmodule

>>> hdl/semigraphics_cell_color_match_top.sv
// top level of the semigraphics cell color matcher
// Encodes one cell of four rgb pixels per word into an 8-color semigraphics
// byte: pixels 0/1 and 2/3 are averaged (truncating) into a left and a right
// half, and 25 candidates (8 palette colors in each of three half patterns,
// plus all black) are scored by the yiq squared distance of both halves. The
// lowest score wins, ties go to the lowest candidate index. The pipeline takes
// one cell every cycle while the output does not stall, in stages: one for
// the averages, three for the distances (dot products, squares, sum), one for
// the candidate scores and five for the minimum tree, whose last register is
// the output register. A stall on the output side holds the whole pipeline;
// s_axis_tready is low only while a result waits and m_axis_tready is low.
// Palette registers are written through cfg_we/cfg_addr/cfg_data. The user
// must write them only while the pipeline is empty, not enforced by the block.
module semigraphics_cell_color_match_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // px0_red, px0_green, px0_blue, px1_red, ..., px3_blue, 8 bits each
    input  logic [sgccm_pkg::IN_W-1:0]         s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // cell_byte [7:0], match_index [12:8], zero fill [15:13]
    output logic [sgccm_pkg::OUT_W-1:0]        m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [sgccm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [sgccm_pkg::PAL_W-1:0]        cfg_data
);

    localparam int LAT = sgccm_pkg::LAT;

    logic                          en;
    logic [LAT-1:0]                vld_reg;
    logic [LAT-1:0]                vld_next;
    logic [sgccm_pkg::PAL_W-1:0]   pal_reg [sgccm_pkg::NUM_COLORS];
    sgccm_pkg::rgb_t               left_reg;
    sgccm_pkg::rgb_t               right_reg;
    sgccm_pkg::rgb_t               left_next;
    sgccm_pkg::rgb_t               right_next;
    logic [sgccm_pkg::HALF_W-1:0]  dl [sgccm_pkg::DIST_N];
    logic [sgccm_pkg::HALF_W-1:0]  dr [sgccm_pkg::DIST_N];
    logic [sgccm_pkg::SCORE_W-1:0] score_reg [sgccm_pkg::NUM_CAND];
    logic [sgccm_pkg::SCORE_W-1:0] score_next [sgccm_pkg::NUM_CAND];
    logic [sgccm_pkg::IDX_W-1:0]   best_idx;

    // whole pipe moves unless a finished word is stuck at the output
    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    // palette registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sgccm_pkg::NUM_COLORS; i++)
            begin
                pal_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            pal_reg[cfg_addr] <= cfg_data;
        end
    end

    // valid bits travel alongside the data
    assign vld_next = {vld_reg[LAT-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // stage 0: half averages, truncating
    always_comb
    begin
        left_next.red    = 8'((9'(s_axis_tdata[7:0])   + 9'(s_axis_tdata[31:24])) >> 1);
        left_next.green  = 8'((9'(s_axis_tdata[15:8])  + 9'(s_axis_tdata[39:32])) >> 1);
        left_next.blue   = 8'((9'(s_axis_tdata[23:16]) + 9'(s_axis_tdata[47:40])) >> 1);
        right_next.red   = 8'((9'(s_axis_tdata[55:48]) + 9'(s_axis_tdata[79:72])) >> 1);
        right_next.green = 8'((9'(s_axis_tdata[63:56]) + 9'(s_axis_tdata[87:80])) >> 1);
        right_next.blue  = 8'((9'(s_axis_tdata[71:64]) + 9'(s_axis_tdata[95:88])) >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    // stages 1 to 3: distances of each half to every palette color and black
    sgccm_half_dist u_left (
        .clk   (clk),
        .en    (en),
        .avg   (left_reg),
        .pal   (pal_reg),
        .dists (dl)
    );

    sgccm_half_dist u_right (
        .clk   (clk),
        .en    (en),
        .avg   (right_reg),
        .pal   (pal_reg),
        .dists (dr)
    );

    // stage 4: candidate scores; an unlit half counts as black
    always_comb
    begin
        for (int k = 0; k < sgccm_pkg::NUM_COLORS; k++)
        begin
            // right only
            score_next[k] = sgccm_pkg::SCORE_W'(dl[sgccm_pkg::DIST_BLACK])
                          + sgccm_pkg::SCORE_W'(dr[k]);
            // left only
            score_next[k + 8] = sgccm_pkg::SCORE_W'(dl[k])
                              + sgccm_pkg::SCORE_W'(dr[sgccm_pkg::DIST_BLACK]);
            // both halves lit
            score_next[k + 16] = sgccm_pkg::SCORE_W'(dl[k]) + sgccm_pkg::SCORE_W'(dr[k]);
        end
        // all black
        score_next[24] = sgccm_pkg::SCORE_W'(dl[sgccm_pkg::DIST_BLACK])
                       + sgccm_pkg::SCORE_W'(dr[sgccm_pkg::DIST_BLACK]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            score_reg <= score_next;
        end
    end

    // stages 5 to 9: minimum search, last register is the output register
    sgccm_min_tree u_tree (
        .clk      (clk),
        .en       (en),
        .score    (score_reg),
        .best_idx (best_idx)
    );

    assign m_axis_tdata = {3'b000, best_idx, sgccm_pkg::cell_byte_of(best_idx)};

endmodule

>>> hdl/sgccm_checker.sv
// port-level checker for the cell color matcher and its bind
`include "semigraphics_cell_color_match_top_defines.svh"

module sgccm_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [sgccm_pkg::OUT_W-1:0]        m_axis_tdata
);

    // a stalled output word stays put
    `SGCCM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // input side only waits on a stuck output word
    `SGCCM_ASSERT_NOW(a_ready_rule, clk, rst_n, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))

    // index in range and top bit of the byte set
    `SGCCM_ASSERT_NOW(a_index_range, clk, rst_n, m_axis_tvalid, (m_axis_tdata[12:8] <= sgccm_pkg::BLACK_INDEX) && m_axis_tdata[7])

    // byte agrees with the winning index
    `SGCCM_ASSERT_NOW(a_byte_index, clk, rst_n, m_axis_tvalid, (m_axis_tdata[12:8] == sgccm_pkg::BLACK_INDEX && m_axis_tdata[7:0] == sgccm_pkg::BYTE_BLACK) || (m_axis_tdata[6:4] == m_axis_tdata[10:8] && ((m_axis_tdata[12:11] == 2'd0 && m_axis_tdata[3:0] == sgccm_pkg::PAT_RIGHT) || (m_axis_tdata[12:11] == 2'd1 && m_axis_tdata[3:0] == sgccm_pkg::PAT_LEFT) || (m_axis_tdata[12:11] == 2'd2 && m_axis_tdata[3:0] == sgccm_pkg::PAT_BOTH))))

endmodule

bind semigraphics_cell_color_match_top sgccm_checker u_sgccm_checker (.*);

>>> verif/tb_semigraphics_cell_color_match_top.sv
// self-checking testbench of the semigraphics cell color matcher
`timescale 1ns / 1ps

// keeps the palette, predicts each cell's byte and index, checks results in order
class cell_match_scoreboard;

    typedef struct {
        logic [7:0] cell_byte;
        logic [4:0] match_index;
    } cell_result_t;

    logic [23:0]  palette [8];
    longint       coef [9];
    cell_result_t pending_cells [$];
    int           mismatches;
    int           checked;

    function new();
        longint unsigned micro [9] = '{299000, 587000, 114000, 595716, 274453,
                                       321263, 211456, 522591, 311135};
        foreach (coef[i])
        begin
            coef[i] = ((micro[i] << sgccm_pkg::COEF_FRAC_BITS) + 500000) / 1000000;
        end
        foreach (palette[i])
        begin
            palette[i] = '0;
        end
        mismatches = 0;
        checked    = 0;
    endfunction

    function void set_color(int idx, logic [23:0] rgb);
        palette[idx] = rgb;
    endfunction

    // yiq squared distance of one averaged half to one color
    function longint unsigned yiq_dist(longint r, longint g, longint b, logic [23:0] c);
        longint dr, dg, db, yd, id, qd;
        dr = r - longint'(c[23:16]);
        dg = g - longint'(c[15:8]);
        db = b - longint'(c[7:0]);
        yd = coef[0] * dr + coef[1] * dg + coef[2] * db;
        id = coef[3] * dr - coef[4] * dg - coef[5] * db;
        qd = coef[6] * dr - coef[7] * dg + coef[8] * db;
        return yd * yd + id * id + qd * qd;
    endfunction

    function void note_cell(logic [95:0] d);
        longint          lh [3];
        longint          rh [3];
        longint unsigned score, best_score;
        logic [23:0]     lc, rc;
        logic [7:0]      bt;
        cell_result_t    best;
        for (int c = 0; c < 3; c++)
        begin
            lh[c] = (longint'(d[c*8 +: 8]) + longint'(d[(3+c)*8 +: 8])) >> 1;
            rh[c] = (longint'(d[(6+c)*8 +: 8]) + longint'(d[(9+c)*8 +: 8])) >> 1;
        end
        best_score = 0;
        best       = '{sgccm_pkg::BYTE_BLACK, sgccm_pkg::BLACK_INDEX};
        for (int k = 0; k < 25; k++)
        begin
            lc = '0;
            rc = '0;
            bt = sgccm_pkg::BYTE_BLACK;
            if (k != sgccm_pkg::BLACK_INDEX)
            begin
                bt[6:4] = 3'(k % 8);
                // pattern 1 right only, 2 left only, 3 both
                if (((k / 8) + 1) & 2)
                begin
                    bt[3:0] = bt[3:0] | sgccm_pkg::PAT_LEFT;
                    lc = palette[k % 8];
                end
                if (((k / 8) + 1) & 1)
                begin
                    bt[3:0] = bt[3:0] | sgccm_pkg::PAT_RIGHT;
                    rc = palette[k % 8];
                end
            end
            score = yiq_dist(lh[0], lh[1], lh[2], lc) + yiq_dist(rh[0], rh[1], rh[2], rc);
            if (k == 0 || score < best_score)
            begin
                best_score = score;
                best       = '{bt, 5'(k)};
            end
        end
        pending_cells.push_back(best);
    endfunction

    function void check_result(logic [15:0] d);
        cell_result_t exp_r;
        checked++;
        if (pending_cells.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %h with no cell pending", d);
            return;
        end
        exp_r = pending_cells.pop_front();
        if (d[7:0] !== exp_r.cell_byte || d[12:8] !== exp_r.match_index || d[15:13] !== 3'b0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: byte %h index %0d expected, byte %h index %0d seen",
                         exp_r.cell_byte, exp_r.match_index, d[7:0], d[12:8]);
        end
    endfunction

endclass

module tb_semigraphics_cell_color_match_top;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // px0_red, px0_green, px0_blue, ..., px3_blue, 8 bits each
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // cell_byte [7:0], match_index [12:8], zero fill [15:13]
    logic [15:0] m_axis_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [23:0] cfg_data;

    cell_match_scoreboard sb;

    // idle percentages for sender and receiver, changed per phase
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    int cells_sent;

    semigraphics_cell_color_match_top dut (.*);

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // receiver stalls at random
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // every accepted result is checked against the oldest pending cell
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000)
        begin
            $display("tb_semigraphics_cell_color_match_top failed");
            $finish;
        end
    end

    // a cell whose two left pixels share one color and two right pixels another
    function automatic logic [95:0] cell_of(logic [23:0] l, logic [23:0] r);
        logic [23:0] lp, rp;
        lp = {l[7:0], l[15:8], l[23:16]};
        rp = {r[7:0], r[15:8], r[23:16]};
        return {rp, rp, lp, lp};
    endfunction

    // color with small per-channel noise, clamped
    function automatic logic [23:0] jitter(logic [23:0] c);
        logic [23:0] o;
        int v;
        for (int i = 0; i < 3; i++)
        begin
            v = int'(c[i*8 +: 8]) + $urandom_range(8) - 4;
            o[i*8 +: 8] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
        end
        return o;
    endfunction

    task automatic send_cell(logic [95:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_cell(d);
        cells_sent++;
    endtask

    // wait for every pending result, then let the pipeline drain
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_cells.size() != 0)
            @(posedge clk);
        repeat (sgccm_pkg::LAT + 4) @(posedge clk);
    endtask

    task automatic write_palette(logic [23:0] colors [8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we   <= 1'b1;
            cfg_addr <= 3'(i);
            cfg_data <= colors[i];
            sb.set_color(i, colors[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // mostly cells near palette colors in random patterns, the rest pure noise
    task automatic random_cells(int n);
        logic [23:0] l, r;
        logic [95:0] d;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 65)
            begin
                l = ($urandom_range(3) == 0) ? 24'h0 : sb.palette[$urandom_range(7)];
                r = ($urandom_range(3) == 0) ? 24'h0 : sb.palette[$urandom_range(7)];
                d = cell_of(jitter(l), jitter(r));
                // split pixel pairs a little so averaging truncates
                d[$urandom_range(95)] ^= 1'b1;
            end
            else
            begin
                d = {$urandom, $urandom, $urandom};
            end
            send_cell(d);
        end
    endtask

    initial
    begin
        logic [23:0] pal [8];
        sb = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_data      = '0;
        send_idle_pct = 14;
        recv_idle_pct = 52;
        cells_sent    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 6; phase++)
        begin
            // idle profile: sender light then receiver light then none
            case (phase / 2)
                0:       begin send_idle_pct = 14; recv_idle_pct = 52; end
                1:       begin send_idle_pct = 52; recv_idle_pct = 14; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            case (phase)
                0: pal = '{24'hff0000, 24'h00ff00, 24'h0000ff, 24'hffff00,
                           24'h00ffff, 24'hff00ff, 24'hffffff, 24'h808080};
                1: pal = '{default: 24'hffffff};
                2: pal = '{default: 24'h000000};
                default:
                    foreach (pal[i])
                        pal[i] = 24'($urandom);
            endcase
            write_palette(pal);

            if (phase == 0)
            begin
                // directed: extremes, each color on both or one half, truncation
                send_cell('0);
                send_cell('1);
                for (int c = 0; c < 8; c++)
                    send_cell(cell_of(pal[c], pal[c]));
                for (int c = 0; c < 4; c++)
                    send_cell(cell_of(pal[c], 24'h0));
                for (int c = 4; c < 8; c++)
                    send_cell(cell_of(24'h0, pal[c]));
                send_cell({24'h020202, 24'h010101, 24'hffffff, 24'hfefefe});
                send_cell({12{8'haa}});
                send_cell({12{8'h55}});
            end
            random_cells(230);
            drain();
        end

        // report the counts and the verdict, then finish
        $display("cells sent %0d, results checked %0d, over six palettes and three idle profiles",
                 cells_sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending_cells.size() == 0)
        begin
            $display("tb_semigraphics_cell_color_match_top passed");
        end
        else
        begin
            $display("mismatches %0d, still pending %0d", sb.mismatches, sb.pending_cells.size());
            $display("tb_semigraphics_cell_color_match_top failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/sgccm_pkg.sv
hdl/sgccm_half_dist.sv
hdl/sgccm_min_tree.sv
hdl/semigraphics_cell_color_match_top.sv
hdl/sgccm_checker.sv
verif/tb_semigraphics_cell_color_match_top.sv
